// ----- rtl/mrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants of the motion record and replay unit
// Mode codes, motor action and event codes, register indexes, reset values
// and the controller to datapath command struct.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // item modes
  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_DRIVE     = 3'd1;
  localparam logic [2:0] MODE_REC_START = 3'd2;
  localparam logic [2:0] MODE_REC_STOP  = 3'd3;
  localparam logic [2:0] MODE_PLAY      = 3'd4;

  // motor actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_EXEC = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // events
  localparam logic [1:0] EVT_NONE        = 2'd0;
  localparam logic [1:0] EVT_REC_STOPPED = 2'd1;
  localparam logic [1:0] EVT_PLAY_DONE   = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_GAP_MS       = 2'd0;
  localparam logic [1:0] CFG_REPLAY_SPEED = 2'd1;
  localparam logic [1:0] CFG_MIN_STEP_MS  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values
  localparam logic [15:0] GAP_MS_RST       = 16'd200;
  localparam logic [7:0]  REPLAY_SPEED_RST = 8'd130;
  localparam logic [15:0] MIN_STEP_MS_RST  = 16'd50;

  localparam logic [7:0] IDLE_CODE = 8'd68;  // 'D'

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;  // latch item fields and read the step store
    logic execute;  // update state, write store, register result
  } dp_cmd_t;

endpackage

// ----- rtl/mrr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_ctrl: sequencing controller
// Two-state machine: accepts an item, runs the execute state in the
// datapath and raises the result strobe in the cycle after.
// ----------------------------------------------------------------------------
module mrr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             result_valid_o,
  output mrr_pkg::dp_cmd_t cmd_o
);
  import mrr_pkg::*;

  state_e state_q, state_d;
  logic   valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    case (state_q)
      ST_IDLE: cmd_o.capture = start;
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        busy          = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.execute;
    end
  end

  assign result_valid_o = valid_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted item did not enter execute");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_valid_o && !busy))
    else $error("execute cycle not followed by result strobe");

endmodule

// ----- rtl/mrr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_datapath: recorder and replay datapath
// Holds the config registers, the step store, the recorder and playback
// state, and the result registers.
// ----------------------------------------------------------------------------
module mrr_datapath #(
  parameter int unsigned STEP_DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  mrr_pkg::dp_cmd_t                        cmd_i,
  input  logic                                    cfg_we_i,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [mrr_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic [2:0]                              mode_i,
  input  logic [7:0]                              drive_code_i,
  input  logic [7:0]                              drive_speed_i,
  input  logic [31:0]                             now_ms_i,
  output logic [1:0]                              motor_action_o,
  output logic [7:0]                              motor_code_o,
  output logic [7:0]                              motor_speed_o,
  output logic [1:0]                              event_res_o,
  output logic [$clog2(STEP_DEPTH+1)-1:0]         steps_stored_o,
  output logic                                    recording_on_o,
  output logic                                    playback_on_o
);
  import mrr_pkg::*;

  localparam int unsigned CW = $clog2(STEP_DEPTH + 1);
  localparam int unsigned AW = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STEP_DEPTH);

  // config
  logic [15:0] cfg_gap_q, cfg_min_step_q;
  logic [7:0]  cfg_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_gap_q      <= GAP_MS_RST;
      cfg_speed_q    <= REPLAY_SPEED_RST;
      cfg_min_step_q <= MIN_STEP_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAP_MS:       cfg_gap_q      <= cfg_wdata_i;
        CFG_REPLAY_SPEED: cfg_speed_q    <= cfg_wdata_i[7:0];
        CFG_MIN_STEP_MS:  cfg_min_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // step store: {code, duration}
  logic [39:0]   step_mem [STEP_DEPTH];
  logic [AW-1:0] rd_addr, wr_addr;
  logic [39:0]   wr_data;
  logic          mem_we;

  // latched item and store read data
  logic [2:0]  mode_q;
  logic [7:0]  code_q, speed_q, rd_code_q;
  logic [31:0] now_q, rd_dur_q;

  // recorder and playback state
  logic [CW-1:0] count_q, count_d, ridx_q, ridx_d;
  logic [7:0]    prev_code_q, prev_code_d;
  logic [31:0]   cmd_start_q, cmd_start_d;
  logic [31:0]   step_start_q, step_start_d;
  logic [31:0]   gap_start_q, gap_start_d;
  logic          rec_q, rec_d, play_q, play_d, in_gap_q, in_gap_d;

  // result
  logic [1:0] act_d, act_q, evt_d, evt_q;
  logic [7:0] mcode_d, mcode_q, mspeed_d, mspeed_q;

  logic [31:0] gap_el, step_el, cmd_el;
  logic        close_ok;

  // playback start always reads entry zero
  assign rd_addr = (mode_i == MODE_PLAY) ? '0 : ridx_q[AW-1:0];
  assign wr_addr = count_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q               <= mode_i;
      code_q               <= drive_code_i;
      speed_q              <= drive_speed_i;
      now_q                <= now_ms_i;
      {rd_code_q, rd_dur_q} <= step_mem[rd_addr];
    end
    if (mem_we) step_mem[wr_addr] <= wr_data;
  end

  assign gap_el  = now_q - gap_start_q;
  assign step_el = now_q - step_start_q;
  assign cmd_el  = now_q - cmd_start_q;
  assign wr_data = {prev_code_q, cmd_el};

  // closing a pending step: non-idle, room left, long enough
  assign close_ok = (prev_code_q != IDLE_CODE) && (count_q != DEPTH_C) &&
                    (cmd_el >= {16'd0, cfg_min_step_q});

  always_comb begin
    count_d      = count_q;
    ridx_d       = ridx_q;
    prev_code_d  = prev_code_q;
    cmd_start_d  = cmd_start_q;
    step_start_d = step_start_q;
    gap_start_d  = gap_start_q;
    rec_d        = rec_q;
    play_d       = play_q;
    in_gap_d     = in_gap_q;
    act_d        = ACT_NONE;
    evt_d        = EVT_NONE;
    mcode_d      = 8'd0;
    mspeed_d     = 8'd0;
    mem_we       = 1'b0;
    case (mode_q)
      MODE_TICK: begin
        if (play_q) begin
          if (in_gap_q) begin
            if (gap_el >= {16'd0, cfg_gap_q}) begin
              in_gap_d = 1'b0;
              if (ridx_q >= count_q) begin
                play_d = 1'b0;
                act_d  = ACT_STOP;
                evt_d  = EVT_PLAY_DONE;
              end else begin
                step_start_d = now_q;
                act_d        = ACT_EXEC;
                mcode_d      = rd_code_q;
                mspeed_d     = cfg_speed_q;
              end
            end
          end else if (step_el >= rd_dur_q) begin
            act_d       = ACT_STOP;
            ridx_d      = ridx_q + 1'b1;
            gap_start_d = now_q;
            in_gap_d    = 1'b1;
          end
        end
      end
      MODE_DRIVE: begin
        act_d   = ACT_EXEC;
        mcode_d = code_q;
        if (rec_q && (code_q != prev_code_q)) begin
          if (close_ok) begin
            mem_we  = cmd_i.execute;
            count_d = count_q + 1'b1;
          end
          prev_code_d = code_q;
          cmd_start_d = now_q;
          mspeed_d    = cfg_speed_q;
        end else begin
          mspeed_d = speed_q;
        end
      end
      MODE_REC_START: begin
        count_d     = '0;
        rec_d       = 1'b1;
        prev_code_d = IDLE_CODE;
        cmd_start_d = now_q;
      end
      MODE_REC_STOP: begin
        if (close_ok) begin
          mem_we  = cmd_i.execute;
          count_d = count_q + 1'b1;
        end
        rec_d = 1'b0;
        act_d = ACT_STOP;
        evt_d = EVT_REC_STOPPED;
      end
      MODE_PLAY: begin
        if (count_q != '0) begin
          play_d       = 1'b1;
          ridx_d       = '0;
          in_gap_d     = 1'b0;
          gap_start_d  = 32'd0;
          step_start_d = now_q;
          act_d        = ACT_EXEC;
          mcode_d      = rd_code_q;
          mspeed_d     = cfg_speed_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ridx_q       <= '0;
      prev_code_q  <= IDLE_CODE;
      cmd_start_q  <= 32'd0;
      step_start_q <= 32'd0;
      gap_start_q  <= 32'd0;
      rec_q        <= 1'b0;
      play_q       <= 1'b0;
      in_gap_q     <= 1'b0;
    end else if (cmd_i.execute) begin
      count_q      <= count_d;
      ridx_q       <= ridx_d;
      prev_code_q  <= prev_code_d;
      cmd_start_q  <= cmd_start_d;
      step_start_q <= step_start_d;
      gap_start_q  <= gap_start_d;
      rec_q        <= rec_d;
      play_q       <= play_d;
      in_gap_q     <= in_gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      act_q    <= act_d;
      evt_q    <= evt_d;
      mcode_q  <= mcode_d;
      mspeed_q <= mspeed_d;
    end
  end

  assign motor_action_o = act_q;
  assign motor_code_o   = mcode_q;
  assign motor_speed_o  = mspeed_q;
  assign event_res_o    = evt_q;
  assign steps_stored_o = count_q;
  assign recording_on_o = rec_q;
  assign playback_on_o  = play_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("step count beyond store depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q) && count_q != '0) |->
      (count_q == $past(count_q) + 1'b1 && $past(mem_we)))
    else $error("step count grew without a store write");

endmodule

// ----- rtl/motion_record_and_replay_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_record_and_replay_unit: teach-and-repeat drive command sequencer
// Records drive command changes as timed steps and replays them on ticks
// with a stopped gap between steps.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  item in  | start, busy            | mode_i, drive_code_i, drive_speed_i,
//           |                        | now_ms_i
//  result   | result_valid_o strobe  | motor_action_o .. playback_on_o
//  config   | cfg_we_i, cfg_idx_i    | cfg_wdata_i (16 bit)
//
// For an item, the accept edge latches the fields and reads the
// step store, the execute cycle updates state and writes the store. The
// result strobe is high in the following cycle, when the next item may
// already be accepted. busy is high during the execute cycle only.
// Reset is asynchronous and active low; the step store is not cleared.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module motion_record_and_replay_unit #(
  parameter int unsigned STEP_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         mode_i,
  input  logic [7:0]                         drive_code_i,
  input  logic [7:0]                         drive_speed_i,
  input  logic [31:0]                        now_ms_i,
  output logic                               result_valid_o,
  output logic [1:0]                         motor_action_o,
  output logic [7:0]                         motor_code_o,
  output logic [7:0]                         motor_speed_o,
  output logic [1:0]                         event_res_o,
  output logic [$clog2(STEP_DEPTH+1)-1:0]    steps_stored_o,
  output logic                               recording_on_o,
  output logic                               playback_on_o,
  input  logic                               cfg_we_i,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mrr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mrr_pkg::*;

  dp_cmd_t cmd;

  mrr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  mrr_datapath #(
    .STEP_DEPTH (STEP_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .drive_code_i   (drive_code_i),
    .drive_speed_i  (drive_speed_i),
    .now_ms_i       (now_ms_i),
    .motor_action_o (motor_action_o),
    .motor_code_o   (motor_code_o),
    .motor_speed_o  (motor_speed_o),
    .event_res_o    (event_res_o),
    .steps_stored_o (steps_stored_o),
    .recording_on_o (recording_on_o),
    .playback_on_o  (playback_on_o)
  );

endmodule
